// ===== design/bftl_pkg.sv =====
// bftl_pkg: shared types and constants for the bitmap font text layout block
// holds the channel beat structs, config struct, queue command type and codes
// no dependencies
package bftl_pkg;

    localparam int ADV_W   = 9;
    localparam int SCALE_W = 16;
    localparam int PROD_W  = ADV_W + SCALE_W;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_CHAR  = 2'd2;

    localparam logic [2:0] CFG_MONO_WIDTH     = 3'd0;
    localparam logic [2:0] CFG_CASE_SENSITIVE = 3'd1;
    localparam logic [2:0] CFG_GLYPH_HEIGHT   = 3'd2;
    localparam logic [2:0] CFG_X_SCALE        = 3'd3;
    localparam logic [2:0] CFG_Y_SCALE        = 3'd4;

    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_NEWLINE  = 8'h0A;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    localparam logic [ADV_W-1:0] SPACE_ADVANCE = 9'd7;

    typedef enum logic [2:0] {
        K_LOAD    = 3'd0,
        K_START   = 3'd1,
        K_SPACE   = 3'd2,
        K_NEWLINE = 3'd3,
        K_TAB     = 3'd4,
        K_GLYPH   = 3'd5,
        K_NOP     = 3'd6
    } kind_t;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [7:0]         char_code;
        logic [15:0]        entry_position;
        logic [7:0]         entry_width;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
    } in_item_t;

    typedef struct packed {
        logic               draw_valid;
        logic signed [15:0] dest_x;
        logic signed [15:0] dest_y;
        logic [15:0]        source_x;
        logic [7:0]         source_width;
        logic signed [15:0] next_x;
        logic signed [15:0] next_y;
    } out_item_t;

    typedef struct packed {
        logic [7:0]  mono_width;
        logic        case_sensitive;
        logic [7:0]  glyph_height;
        logic [15:0] x_scale;
        logic [15:0] y_scale;
    } cfg_t;

    typedef struct packed {
        kind_t              kind;
        logic [7:0]         code;
        logic               in_range;
        logic [15:0]        entry_position;
        logic [7:0]         entry_width;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
    } cmd_t;

endpackage

// ===== design/bftl_front.sv =====
// bftl_front: accepts input beats, classifies them and folds case
// depends on bftl_pkg; feeds bftl_queue
module bftl_front
    import bftl_pkg::*;
#(
    parameter int GLYPH_COUNT = 256
)
(
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_data,
    input  cfg_t     cfg,
    input  logic     q_full,
    output logic     q_push,
    output cmd_t     q_cmd
);

    logic [7:0] folded;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        folded = in_data.char_code;
        if (!cfg.case_sensitive && in_data.char_code >= CH_UPPER_A
            && in_data.char_code <= CH_UPPER_Z)
        begin
            folded = in_data.char_code + CASE_OFFSET;
        end

        q_cmd.code           = (in_data.opcode == OP_LOAD) ? in_data.char_code : folded;
        q_cmd.in_range       = (32'(q_cmd.code) < GLYPH_COUNT);
        q_cmd.entry_position = in_data.entry_position;
        q_cmd.entry_width    = in_data.entry_width;
        q_cmd.start_x        = in_data.start_x;
        q_cmd.start_y        = in_data.start_y;

        case (in_data.opcode)
            OP_LOAD:  q_cmd.kind = K_LOAD;
            OP_START: q_cmd.kind = K_START;
            OP_CHAR:
            begin
                case (in_data.char_code)
                    CH_SPACE:   q_cmd.kind = K_SPACE;
                    CH_NEWLINE: q_cmd.kind = K_NEWLINE;
                    CH_TAB:     q_cmd.kind = K_TAB;
                    default:    q_cmd.kind = K_GLYPH;
                endcase
            end
            default:  q_cmd.kind = K_NOP;
        endcase
    end

endmodule

// ===== design/bftl_queue.sv =====
// bftl_queue: two-entry command queue between front and back
// depends on bftl_pkg
module bftl_queue
    import bftl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic full,
    output logic empty
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== design/bftl_back.sv =====
// bftl_back: executes queued commands: glyph table, tab remainder, scaled cursor moves
// depends on bftl_pkg; fed by bftl_queue, drives the output register
module bftl_back
    import bftl_pkg::*;
#(
    parameter int GLYPH_COUNT = 256,
    parameter int COORD_BITS  = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      q_empty,
    input  cmd_t      q_head,
    output logic      q_pop,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    localparam int IDX_W = $clog2(GLYPH_COUNT);
    localparam int SUM_W = ((COORD_BITS + 8 > PROD_W + 1) ? COORD_BITS + 8 : PROD_W + 1) + 1;
    localparam int QW    = SUM_W - 8;
    localparam int DW    = COORD_BITS + 1;
    localparam int CNT_W = $clog2(DW + 1);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_READ = 6'b000010,
        ST_DIV  = 6'b000100,
        ST_MUL  = 6'b001000,
        ST_ADD  = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [15:0] src_mem [GLYPH_COUNT];
    logic [7:0]  wid_mem [GLYPH_COUNT];
    logic [15:0] src_rd_reg;
    logic [7:0]  wid_rd_reg;

    cmd_t                         cmd_reg;
    logic signed [COORD_BITS-1:0] cursor_x_reg;
    logic signed [COORD_BITS-1:0] cursor_y_reg;
    logic signed [COORD_BITS-1:0] origin_reg;
    logic [ADV_W-1:0]             adv_reg;
    logic [SCALE_W-1:0]           scale_reg;
    logic [PROD_W-1:0]            prod_reg;
    logic                         to_y_reg;
    logic [DW-1:0]                dvd_reg;
    logic [7:0]                   rem_reg;
    logic                         neg_reg;
    logic [CNT_W-1:0]             cnt_reg;

    logic        draw_reg;
    logic [15:0] dest_x_reg;
    logic [15:0] dest_y_reg;
    logic [15:0] src_x_reg;
    logic [7:0]  src_w_reg;

    logic      out_valid_reg;
    out_item_t out_data_reg;

    logic                         issue;
    logic                         out_free;
    logic [SCALE_W-1:0]           vscale;
    logic signed [DW-1:0]         delta;
    logic [DW-1:0]                dist_mag;
    logic [8:0]                   trial;
    logic [7:0]                   rem_step;
    logic [ADV_W-1:0]             tab_adv;
    logic signed [COORD_BITS-1:0] pos;
    logic signed [SUM_W-1:0]      sum;
    logic signed [QW-1:0]         quot;
    logic signed [COORD_BITS-1:0] new_coord;

    function automatic logic signed [COORD_BITS-1:0] sat_coord(input logic signed [QW-1:0] v);
        logic [QW-COORD_BITS:0] upper;
        upper = v[QW-1:COORD_BITS-1];
        if ((&upper) || !(|upper))
        begin
            return v[COORD_BITS-1:0];
        end
        else if (v[QW-1])
        begin
            return {1'b1, {(COORD_BITS-1){1'b0}}};
        end
        else
        begin
            return {1'b0, {(COORD_BITS-1){1'b1}}};
        end
    endfunction

    assign issue     = state_reg[0] && !q_empty;
    assign q_pop     = issue;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign vscale    = (cfg.y_scale != '0) ? cfg.y_scale : cfg.x_scale;

    always_comb
    begin
        delta    = DW'(cursor_x_reg) - DW'(origin_reg);
        dist_mag = delta[DW-1] ? DW'(-delta) : DW'(delta);

        // one restoring step of |d| / glyph_height, remainder only
        trial    = {rem_reg, dvd_reg[DW-1]};
        rem_step = (trial >= {1'b0, cfg.glyph_height}) ?
                   8'(trial - {1'b0, cfg.glyph_height}) : trial[7:0];
        // remainder carries the sign of the distance
        tab_adv  = neg_reg ? (ADV_W'(cfg.glyph_height) + ADV_W'(rem_step)) :
                             (ADV_W'(cfg.glyph_height) - ADV_W'(rem_step));

        pos  = to_y_reg ? cursor_y_reg : cursor_x_reg;
        sum  = (SUM_W'(pos) <<< 8) + SUM_W'(prod_reg);
        // divide by 256 truncating toward zero
        quot = QW'(sum >>> 8);
        if (sum[SUM_W-1] && (sum[7:0] != 8'd0))
        begin
            quot = quot + QW'(1);
        end
        new_coord = sat_coord(quot);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    case (q_head.kind)
                        K_SPACE, K_NEWLINE: state_next = ST_MUL;
                        K_TAB:   state_next = (cfg.glyph_height == 8'd0) ? ST_MUL : ST_DIV;
                        K_GLYPH: state_next = ST_READ;
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_READ: state_next = ST_MUL;
            ST_DIV:  state_next = (cnt_reg == CNT_W'(1)) ? ST_MUL : ST_DIV;
            ST_MUL:  state_next = ST_ADD;
            ST_ADD:  state_next = ST_DONE;
            ST_DONE: state_next = out_free ? ST_IDLE : ST_DONE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (issue && q_head.kind == K_LOAD && q_head.in_range)
        begin
            src_mem[q_head.code[IDX_W-1:0]] <= q_head.entry_position;
            wid_mem[q_head.code[IDX_W-1:0]] <= q_head.entry_width;
        end
        src_rd_reg <= src_mem[q_head.code[IDX_W-1:0]];
        wid_rd_reg <= wid_mem[q_head.code[IDX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cursor_x_reg  <= '0;
            cursor_y_reg  <= '0;
            origin_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (issue && q_head.kind == K_START)
            begin
                cursor_x_reg <= sat_coord(QW'(q_head.start_x));
                cursor_y_reg <= sat_coord(QW'(q_head.start_y));
                origin_reg   <= sat_coord(QW'(q_head.start_x));
            end
            if (state_reg == ST_ADD)
            begin
                if (to_y_reg)
                begin
                    cursor_y_reg <= new_coord;
                    cursor_x_reg <= origin_reg;
                end
                else
                begin
                    cursor_x_reg <= new_coord;
                end
            end
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                cmd_reg    <= q_head;
                draw_reg   <= 1'b0;
                dest_x_reg <= '0;
                dest_y_reg <= '0;
                src_x_reg  <= '0;
                src_w_reg  <= '0;
                to_y_reg   <= (q_head.kind == K_NEWLINE);
                scale_reg  <= (q_head.kind == K_NEWLINE) ? vscale : cfg.x_scale;
                dvd_reg    <= dist_mag;
                neg_reg    <= delta[DW-1];
                rem_reg    <= '0;
                cnt_reg    <= CNT_W'(DW);
                case (q_head.kind)
                    K_SPACE:   adv_reg <= (cfg.mono_width != '0) ?
                                          ADV_W'(cfg.mono_width) : SPACE_ADVANCE;
                    K_NEWLINE: adv_reg <= ADV_W'(cfg.glyph_height);
                    default:   adv_reg <= '0;
                endcase
            end
            ST_READ:
            begin
                draw_reg   <= 1'b1;
                dest_x_reg <= 16'(cursor_x_reg);
                dest_y_reg <= 16'(cursor_y_reg);
                src_x_reg  <= cmd_reg.in_range ? src_rd_reg : 16'd0;
                if (cfg.mono_width != '0)
                begin
                    src_w_reg <= cfg.mono_width;
                    adv_reg   <= ADV_W'(cfg.mono_width);
                end
                else
                begin
                    src_w_reg <= cmd_reg.in_range ? wid_rd_reg : 8'd0;
                    adv_reg   <= cmd_reg.in_range ? ADV_W'(wid_rd_reg) + ADV_W'(1) : ADV_W'(1);
                end
            end
            ST_DIV:
            begin
                rem_reg <= rem_step;
                dvd_reg <= {dvd_reg[DW-2:0], 1'b0};
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    adv_reg <= tab_adv;
                end
            end
            ST_MUL:
            begin
                prod_reg <= PROD_W'(adv_reg) * PROD_W'(scale_reg);
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_data_reg.draw_valid   <= draw_reg;
                    out_data_reg.dest_x       <= dest_x_reg;
                    out_data_reg.dest_y       <= dest_y_reg;
                    out_data_reg.source_x     <= src_x_reg;
                    out_data_reg.source_width <= src_w_reg;
                    out_data_reg.next_x       <= 16'(cursor_x_reg);
                    out_data_reg.next_y       <= 16'(cursor_y_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== design/bitmap_font_text_layout.sv =====
// Bitmap font text layout. Load beats fill a GLYPH_COUNT-entry glyph table
// (source x, width); start beats set the origin and cursor; character beats move
// the cursor or emit a draw rectangle, one result beat per input beat. Advances
// are scaled by 8.8 factors, truncated toward zero and saturated to COORD_BITS.
// Input beats enter a two-entry queue and are executed one at a time by a
// sequencer: load, start and ignored opcodes go straight to done, space and
// newline pass through multiply and add, glyphs first take a registered table
// read, and tabs with a nonzero glyph_height first run a bit-serial remainder.
// The result register holds a finished beat while the next one is being
// worked on. Table entries are undefined until loaded. Config writes are taken
// every cycle and must only happen while the block is idle.
module bitmap_font_text_layout
    import bftl_pkg::*;
#(
    parameter int GLYPH_COUNT = 256,
    parameter int COORD_BITS  = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t cfg_reg;
    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    cmd_t q_cmd;
    cmd_t q_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mono_width     <= 8'd0;
            cfg_reg.case_sensitive <= 1'b1;
            cfg_reg.glyph_height   <= 8'd16;
            cfg_reg.x_scale        <= 16'd256;
            cfg_reg.y_scale        <= 16'd256;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MONO_WIDTH:     cfg_reg.mono_width     <= cfg_data[7:0];
                CFG_CASE_SENSITIVE: cfg_reg.case_sensitive <= cfg_data[0];
                CFG_GLYPH_HEIGHT:   cfg_reg.glyph_height   <= cfg_data[7:0];
                CFG_X_SCALE:        cfg_reg.x_scale        <= cfg_data;
                CFG_Y_SCALE:        cfg_reg.y_scale        <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    bftl_front #(
        .GLYPH_COUNT(GLYPH_COUNT)
    ) u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_cmd)
    );

    bftl_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    bftl_back #(
        .GLYPH_COUNT(GLYPH_COUNT),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
